// ----- rtl/chm_pkg.sv -----
// shared types and constants of the chained hash map
`default_nettype none
package chm_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 3;
    localparam int TOTAL_W = 9;
    localparam int CFG_W   = 8;
    localparam int DIV_W   = 8;
    localparam int DIGIT_W = 4;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 8'd101;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_UPDATED   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_HEAD,
        ST_WALK,
        ST_ACT,
        ST_LINK
    } state_t;

endpackage
`default_nettype wire

// ----- rtl/chm_ram.sv -----
// simple dual-port ram with registered read
`default_nettype none
module chm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/chm_rem.sv -----
// iterative key remainder unit, several dividend bits per cycle
`default_nettype none
module chm_rem
    import chm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [KEY_W-1:0] dividend,
    input  wire logic [DIV_W-1:0] divisor,
    output logic                  done,
    output logic      [DIV_W-1:0] rem
);

    localparam int STEPS = KEY_W / DIGIT_W;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [KEY_W-1:0] shift_reg, shift_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    // restoring steps, remainder always stays below the divisor
    always_comb begin
        logic [DIV_W:0] trial;
        trial      = '0;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        for (int i = 0; i < DIGIT_W; i++) begin
            trial      = {rem_next, shift_next[KEY_W-1]};
            shift_next = {shift_next[KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                trial = trial - {1'b0, div_reg};
            end
            rem_next = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end else if (busy_reg) begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// ----- rtl/chained_hash_map.sv -----
// top level of the chained hash map: sequencer, table state and result register
//
// Key-value table with separate chaining. The bucket is the key modulo the
// configured bucket count (0 acts as 1, values above BUCKETS act as BUCKETS),
// computed by a remainder unit that takes 4 key bits a cycle. Then the bucket
// head is read, the chain is walked one node per cycle through the node
// memories, and the update is made in ACT once the result register is free,
// followed by a LINK step when a new node is linked behind a chain tail. One
// item is in work at a time, and the next item is taken while the previous
// result still waits on the m_ side. After reset and after every bucket_count
// write the table is emptied: a clearing pass resets all BUCKETS bucket heads,
// during which no item is accepted.
`default_nettype none
module chained_hash_map
    import chm_pkg::*;
#(
    parameter int BUCKETS = 128,
    parameter int NODES   = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [KIND_W-1:0]  s_kind,
    input  wire logic [KEY_W-1:0]   s_key,
    input  wire logic [VAL_W-1:0]   s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [STAT_W-1:0]  m_status,
    output logic      [VAL_W-1:0]   m_read_value,
    output logic      [TOTAL_W-1:0] m_entry_total
);

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int NODE_W = $clog2(NODES);
    localparam int LINK_W = $clog2(NODES + 1);
    localparam int TOP_W  = $clog2(NODES + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(NODES);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  bc_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [BKT_W-1:0]  bucket_reg;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [TOP_W-1:0]  steps_reg, steps_next;
    logic              found_reg, found_next;
    logic [NODE_W-1:0] new_node_reg;
    logic [TOP_W-1:0]  top_reg, top_next;
    logic [TOP_W-1:0]  lw_reg, lw_next;
    logic [TOP_W-1:0]  cnt_reg, cnt_next;
    logic [BKT_W-1:0]  clr_reg;
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [VAL_W-1:0]  out_rd_reg, out_rd_next;

    logic              accept;
    logic              act_go;
    logic              link_pending;
    logic [DIV_W-1:0]  active_count;
    logic              rem_done;
    logic [DIV_W-1:0]  rem;
    logic [NODE_W-1:0] pop_node;

    // memory ports
    logic              head_we, head_re;
    logic [BKT_W-1:0]  head_waddr, head_raddr;
    logic [LINK_W-1:0] head_wdata, head_rdata;
    logic              key_we, node_re;
    logic [NODE_W-1:0] key_waddr, node_raddr;
    logic [KEY_W-1:0]  key_rdata;
    logic              val_we;
    logic [NODE_W-1:0] val_waddr;
    logic [VAL_W-1:0]  val_wdata, val_rdata;
    logic              link_we;
    logic [NODE_W-1:0] link_waddr;
    logic [LINK_W-1:0] link_wdata, link_rdata;
    logic              free_we, free_re;
    logic [NODE_W-1:0] free_waddr, free_raddr;
    logic [NODE_W-1:0] free_rdata;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign act_go  = (state_reg == ST_ACT) && (!out_valid_reg || m_ready);

    always_comb begin
        if (bc_reg == '0) begin
            active_count = DIV_W'(1);
        end else if (32'(bc_reg) > BUCKETS) begin
            active_count = DIV_W'(BUCKETS);
        end else begin
            active_count = bc_reg;
        end
    end

    // below the low-water mark the free stack still holds its reset contents
    assign pop_node = (top_reg == lw_reg) ? NODE_W'(top_reg - 1'b1) : free_rdata;

    chm_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .dividend (s_key),
        .divisor  (active_count),
        .done     (rem_done),
        .rem      (rem)
    );

    chm_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_head (
        .aclk (aclk), .we (head_we), .waddr (head_waddr), .wdata (head_wdata),
        .re (head_re), .raddr (head_raddr), .rdata (head_rdata)
    );

    chm_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key (
        .aclk (aclk), .we (key_we), .waddr (key_waddr), .wdata (key_reg),
        .re (node_re), .raddr (node_raddr), .rdata (key_rdata)
    );

    chm_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_val (
        .aclk (aclk), .we (val_we), .waddr (val_waddr), .wdata (val_wdata),
        .re (node_re), .raddr (node_raddr), .rdata (val_rdata)
    );

    chm_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_link (
        .aclk (aclk), .we (link_we), .waddr (link_waddr), .wdata (link_wdata),
        .re (node_re), .raddr (node_raddr), .rdata (link_rdata)
    );

    chm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_free (
        .aclk (aclk), .we (free_we), .waddr (free_waddr), .wdata (cur_reg[NODE_W-1:0]),
        .re (free_re), .raddr (free_raddr), .rdata (free_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        if (cfg_we) begin
            state_next = ST_CLEAR;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    if (clr_reg == BKT_W'(BUCKETS - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        state_next = ST_HASH;
                    end
                end
                ST_HASH: begin
                    if (rem_done) begin
                        state_next = ST_HEAD;
                    end
                end
                ST_HEAD: begin
                    state_next = (head_rdata == NIL) ? ST_ACT : ST_WALK;
                end
                ST_WALK: begin
                    if (key_rdata == key_reg || link_rdata == NIL
                        || steps_reg + 1'b1 == TOP_W'(NODES)) begin
                        state_next = ST_ACT;
                    end
                end
                ST_ACT: begin
                    if (act_go) begin
                        state_next = link_pending ? ST_LINK : ST_IDLE;
                    end
                end
                ST_LINK: begin
                    state_next = ST_IDLE;
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // datapath and memory controls
    always_comb begin
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        steps_next      = steps_reg;
        found_next      = found_reg;
        top_next        = top_reg;
        lw_next         = lw_reg;
        cnt_next        = cnt_reg;
        out_status_next = out_status_reg;
        out_rd_next     = out_rd_reg;
        link_pending    = 1'b0;

        head_we    = 1'b0;
        head_waddr = bucket_reg;
        head_wdata = NIL;
        head_re    = 1'b0;
        head_raddr = BKT_W'(rem);
        key_we     = 1'b0;
        key_waddr  = pop_node;
        node_re    = 1'b0;
        node_raddr = NODE_W'(head_rdata);
        val_we     = 1'b0;
        val_waddr  = pop_node;
        val_wdata  = value_reg;
        link_we    = 1'b0;
        link_waddr = pop_node;
        link_wdata = NIL;
        free_we    = 1'b0;
        free_waddr = NODE_W'(top_reg);
        free_re    = 1'b0;
        free_raddr = NODE_W'(top_reg - 1'b1);

        unique case (state_reg)
            ST_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
            end
            ST_IDLE: begin
            end
            ST_HASH: begin
                free_re = 1'b1;
                head_re = rem_done;
            end
            ST_HEAD: begin
                cur_next   = head_rdata;
                prev_next  = NIL;
                steps_next = '0;
                found_next = (head_rdata != NIL);
                node_re    = (head_rdata != NIL);
            end
            ST_WALK: begin
                if (key_rdata != key_reg) begin
                    prev_next  = cur_reg;
                    cur_next   = link_rdata;
                    steps_next = steps_reg + 1'b1;
                    if (link_rdata == NIL || steps_reg + 1'b1 == TOP_W'(NODES)) begin
                        found_next = 1'b0;
                    end else begin
                        node_re    = 1'b1;
                        node_raddr = NODE_W'(link_rdata);
                    end
                end
            end
            ST_ACT: begin
                if (act_go) begin
                    out_status_next = STAT_NOT_FOUND;
                    out_rd_next     = '0;
                    priority if (kind_reg == KIND_INSERT) begin
                        if (found_reg) begin
                            val_we          = 1'b1;
                            val_waddr       = NODE_W'(cur_reg);
                            out_status_next = STAT_UPDATED;
                        end else if (top_reg == '0) begin
                            out_status_next = STAT_FULL;
                        end else begin
                            key_we   = 1'b1;
                            val_we   = 1'b1;
                            link_we  = 1'b1;
                            top_next = top_reg - 1'b1;
                            if (top_reg == lw_reg) begin
                                lw_next = top_reg - 1'b1;
                            end
                            cnt_next = cnt_reg + 1'b1;
                            if (prev_reg == NIL) begin
                                head_we    = 1'b1;
                                head_wdata = LINK_W'(pop_node);
                            end else begin
                                link_pending = 1'b1;
                            end
                            out_status_next = STAT_INSERTED;
                        end
                    end else if (kind_reg == KIND_LOOKUP) begin
                        if (found_reg) begin
                            out_status_next = STAT_FOUND;
                            out_rd_next     = val_rdata;
                        end
                    end else if (kind_reg == KIND_REMOVE) begin
                        if (found_reg) begin
                            if (prev_reg == NIL) begin
                                head_we    = 1'b1;
                                head_wdata = link_rdata;
                            end else begin
                                link_we    = 1'b1;
                                link_waddr = NODE_W'(prev_reg);
                                link_wdata = link_rdata;
                            end
                            if (top_reg < TOP_W'(NODES)) begin
                                free_we  = 1'b1;
                                top_next = top_reg + 1'b1;
                            end
                            if (cnt_reg != '0) begin
                                cnt_next = cnt_reg - 1'b1;
                            end
                            out_status_next = STAT_REMOVED;
                        end
                    end else begin
                        out_status_next = STAT_NOT_FOUND;
                    end
                end
            end
            ST_LINK: begin
                link_we    = 1'b1;
                link_waddr = NODE_W'(prev_reg);
                link_wdata = LINK_W'(new_node_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            bc_reg        <= BUCKET_COUNT_RESET;
            top_reg       <= TOP_W'(NODES);
            lw_reg        <= TOP_W'(NODES);
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (act_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                bc_reg  <= cfg_wdata;
                top_reg <= TOP_W'(NODES);
                lw_reg  <= TOP_W'(NODES);
                cnt_reg <= '0;
                clr_reg <= '0;
            end else begin
                top_reg <= top_next;
                lw_reg  <= lw_next;
                cnt_reg <= cnt_next;
                if (state_reg == ST_CLEAR) begin
                    clr_reg <= clr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= s_kind;
            key_reg   <= s_key;
            value_reg <= s_value;
        end
        if (state_reg == ST_HASH && rem_done) begin
            bucket_reg <= BKT_W'(rem);
        end
        if (act_go) begin
            new_node_reg <= pop_node;
        end
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        steps_reg      <= steps_next;
        found_reg      <= found_next;
        out_status_reg <= out_status_next;
        out_rd_reg     <= out_rd_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_read_value  = out_rd_reg;
    assign m_entry_total = TOTAL_W'(cnt_reg);

endmodule
`default_nettype wire

// ----- test/chained_hash_map_test.sv -----
// testbench of the chained hash map: directed and random requests checked against a table model
`timescale 1ns / 1ps
module chained_hash_map_test
    import chm_pkg::*;
();

    localparam int BUCKETS = 128;
    localparam int NODES = 256;
    localparam int NIL = NODES;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    class hash_map_scoreboard;
        int unsigned active_count;
        int unsigned head[BUCKETS];
        logic [KEY_W-1:0] nkey[NODES];
        logic [VAL_W-1:0] nval[NODES];
        int unsigned nlink[NODES];
        int unsigned free_list[NODES];
        int unsigned free_top;
        int unsigned entries;
        logic [STAT_W-1:0] want_status[$];
        logic [VAL_W-1:0] want_value[$];
        logic [TOTAL_W-1:0] want_total[$];
        int errors;
        int checked;

        function void empty_table(logic [CFG_W-1:0] count);
            active_count = (count == 0) ? 1 : (count > BUCKETS ? BUCKETS : count);
            foreach (head[i]) head[i] = NIL;
            foreach (free_list[i]) free_list[i] = i;
            free_top = NODES;
            entries = 0;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                   logic [VAL_W-1:0] value);
            int unsigned b, cur, prev, n;
            logic [STAT_W-1:0] st;
            logic [VAL_W-1:0] rd;
            b = key % active_count;
            cur = head[b];
            prev = NIL;
            st = STAT_NOT_FOUND;
            rd = '0;
            while (cur != NIL && nkey[cur] != key) begin
                prev = cur;
                cur = nlink[cur];
            end
            if (kind == KIND_INSERT) begin
                if (cur != NIL) begin
                    nval[cur] = value;
                    st = STAT_UPDATED;
                end else if (free_top == 0) begin
                    st = STAT_FULL;
                end else begin
                    free_top--;
                    n = free_list[free_top];
                    nkey[n] = key;
                    nval[n] = value;
                    nlink[n] = NIL;
                    if (prev == NIL) head[b] = n;
                    else nlink[prev] = n;
                    entries++;
                    st = STAT_INSERTED;
                end
            end else if (kind == KIND_LOOKUP) begin
                if (cur != NIL) begin
                    rd = nval[cur];
                    st = STAT_FOUND;
                end
            end else if (kind == KIND_REMOVE) begin
                if (cur != NIL) begin
                    if (prev == NIL) head[b] = nlink[cur];
                    else nlink[prev] = nlink[cur];
                    free_list[free_top] = cur;
                    free_top++;
                    entries--;
                    st = STAT_REMOVED;
                end
            end
            want_status.push_back(st);
            want_value.push_back(rd);
            want_total.push_back(entries[TOTAL_W-1:0]);
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [VAL_W-1:0] rd,
                                   logic [TOTAL_W-1:0] total);
            logic [STAT_W-1:0] es;
            logic [VAL_W-1:0] ev;
            logic [TOTAL_W-1:0] et;
            if (want_status.size() == 0) begin
                $display("%0t: unexpected result status %0d", $time, st);
                errors++;
                return;
            end
            es = want_status.pop_front();
            ev = want_value.pop_front();
            et = want_total.pop_front();
            checked++;
            if (st !== es) begin
                $display("%0t: status expected %0d actual %0d", $time, es, st);
                errors++;
            end
            if (rd !== ev) begin
                $display("%0t: read_value expected %h actual %h", $time, ev, rd);
                errors++;
            end
            if (total !== et) begin
                $display("%0t: entry_total expected %0d actual %0d", $time, et, total);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic [KIND_W-1:0] s_kind = '0;
    logic [KEY_W-1:0] s_key = '0;
    logic [VAL_W-1:0] s_value = '0;
    logic m_valid;
    logic m_ready = 0;
    logic [STAT_W-1:0] m_status;
    logic [VAL_W-1:0] m_read_value;
    logic [TOTAL_W-1:0] m_entry_total;

    hash_map_scoreboard table_model = new();
    bit hold_off = 0;
    int idle_cycles = 0;
    int sent = 0;
    int configs = 0;
    logic [KEY_W-1:0] key_pool[16];

    always #5 aclk = ~aclk;

    chained_hash_map i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_key(s_key),
        .s_value(s_value), .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_read_value(m_read_value), .m_entry_total(m_entry_total)
    );

    // result side: check at the edge, then pick the next stall
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            table_model.check_result(m_status, m_read_value, m_entry_total);
        if (hold_off) m_ready <= 1'b0;
        else if (($time / 2000) % 3 == 0) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired");
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                logic [VAL_W-1:0] value);
        s_valid <= 1'b1;
        s_kind <= kind;
        s_key <= key;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        table_model.note_request(kind, key, value);
        sent++;
        // bursts with random gaps
        if ($urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic write_bucket_count(logic [CFG_W-1:0] count);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (table_model.want_status.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_we <= 1'b0;
        table_model.empty_table(count);
        configs++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key(logic [CFG_W-1:0] count);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return key_pool[$urandom_range(0, 15)];
        if (r < 8) return $urandom_range(0, 3) * ((count == 0) ? 1 : count) + 5;
        return $urandom;
    endfunction

    // non-insert kinds, now and then the unused code
    function automatic logic [KIND_W-1:0] pick_kind();
        int unsigned r;
        r = $urandom_range(0, 20);
        if (r == 0) return KIND_UNUSED;
        return (r < 11) ? KIND_LOOKUP : KIND_REMOVE;
    endfunction

    task automatic random_phase(int count_items, logic [CFG_W-1:0] count);
        logic [KIND_W-1:0] k;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (count_items) begin
            k = $urandom_range(0, 9) < 5 ? KIND_INSERT : pick_kind();
            send_request(k, pick_key(count), $urandom);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] counts[5];
        int i;
        counts = '{8'd1, 8'd0, 8'd128, 8'd255, 8'd7};
        table_model.empty_table(BUCKET_COUNT_RESET);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every kind, chain collisions at reset count
        send_request(KIND_LOOKUP, 32'h0, 32'h0);
        send_request(KIND_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_request(KIND_INSERT, 32'd101, 32'hA5A5_5A5A);
        send_request(KIND_INSERT, 32'd202, 32'h5A5A_A5A5);
        send_request(KIND_INSERT, 32'd101, 32'h1234_5678);
        send_request(KIND_LOOKUP, 32'd101, 32'hDEAD_BEEF);
        send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_request(KIND_REMOVE, 32'd101, 32'h0);
        send_request(KIND_LOOKUP, 32'd202, 32'h0);
        send_request(KIND_REMOVE, 32'd101, 32'h0);
        send_request(KIND_UNUSED, 32'd202, 32'hFFFF_FFFF);
        send_request(KIND_REMOVE, 32'd0, 32'h0);
        send_request(KIND_LOOKUP, 32'd0, 32'h0);

        // fill the pool with one bucket in use, then overflow it
        write_bucket_count(8'd1);
        for (i = 0; i < NODES + 3; i++) send_request(KIND_INSERT, i * 3, ~i);
        send_request(KIND_INSERT, 32'd30, 32'h7777_7777);
        send_request(KIND_LOOKUP, 32'd765, 32'h0);
        send_request(KIND_REMOVE, 32'd0, 32'h0);
        send_request(KIND_INSERT, 32'hFFFF_FFFF, 32'h1);

        // receiver holds off while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            random_phase(40, 8'd1);
        join

        foreach (counts[j]) begin
            write_bucket_count(counts[j]);
            random_phase(130, counts[j]);
        end

        s_valid <= 1'b0;
        while (table_model.want_status.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        $display("%0d requests sent, %0d results checked, %0d bucket count settings",
                 sent, table_model.checked, configs + 1);
        if (table_model.errors == 0 && table_model.want_status.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- chained_hash_map.f -----
rtl/chm_pkg.sv
rtl/chm_ram.sv
rtl/chm_rem.sv
rtl/chained_hash_map.sv
test/chained_hash_map_test.sv
